/* rtl/core/grid_astar_path_search_unit_defines.svh */
// Assertion macros used by the checker file of the path search unit.
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define GAPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gaps check failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define GAPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gaps check failed");

`endif

/* rtl/core/gaps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and constants of the grid path search unit.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int GRID_DIM_DEF = 16;
  localparam int STEP_COST    = 10;

  localparam logic [4:0] DIM_RESET = 5'd13;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // node status codes
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  typedef enum logic [1:0] {
    FN_FREE   = 2'd0,
    FN_BLOCK  = 2'd1,
    FN_SEARCH = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] goal_row;
    logic [3:0] goal_col;
    logic [8:0] path_index;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [8:0] path_length;
    logic [3:0] step_row;
    logic [3:0] step_col;
    logic       index_bad;
  } out_t;

endpackage

/* rtl/core/gaps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaps_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module gaps_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/gaps_fscore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaps_fscore
// Shared score unit: F = G + 10 * Manhattan distance, and best-so-far compare.
// ----------------------------------------------------------------------------
module gaps_fscore
  import gaps_pkg::*;
#(
  parameter int CW  = 4,
  parameter int CGW = 12,
  parameter int SW  = 9,
  parameter int FW  = 14
) (
  input  logic [CGW-1:0] cost,
  input  logic [CW-1:0]  row,
  input  logic [CW-1:0]  col,
  input  logic [3:0]     goal_row,
  input  logic [3:0]     goal_col,
  input  logic [SW-1:0]  stamp,
  input  logic           have,
  input  logic [FW-1:0]  best_f,
  input  logic [SW-1:0]  best_s,
  output logic [FW-1:0]  f,
  output logic           better
);

  localparam int HW = (CW > 4) ? CW : 4;

  logic [HW-1:0] r_x, c_x, gr_x, gc_x, dr, dc;
  logic [HW:0]   dsum;
  logic [FW-1:0] h10;

  // distance, times ten as two shifted adds
  always_comb begin
    r_x  = HW'(row);
    c_x  = HW'(col);
    gr_x = HW'(goal_row);
    gc_x = HW'(goal_col);
    dr   = (gr_x > r_x) ? gr_x - r_x : r_x - gr_x;
    dc   = (gc_x > c_x) ? gc_x - c_x : c_x - gc_x;
    dsum = {1'b0, dr} + {1'b0, dc};
    h10  = (FW'(dsum) << 3) + (FW'(dsum) << 1);
    f    = FW'(cost) + h10;
    // lower F wins; on a tie the later opened cell wins
    better = !have || (f < best_f) || ((f == best_f) && (stamp > best_s));
  end

endmodule

/* rtl/core/grid_astar_path_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// A* search over a four-neighbour obstacle grid with stored path readback.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_ready is high only while the sequencer is
// idle. With N = 2**(2*clog2(GRID_DIM)) node memory entries (256 at the
// default size), a search first clears all N entries of the node memory and
// checks the start, then opens the start cell, then for each expanded cell
// scans every node entry through the one score/compare unit, visits the
// neighbours and closes the cell, then makes two passes over the parent
// chain, and loads the result. After reset the obstacle memory is cleared
// before the first item is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit
  import gaps_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int IW    = 2 * CW;
  localparam int ND    = 1 << IW;
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int LW    = $clog2(CELLS + 1);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CGW   = $clog2(STEP_COST * CELLS + 1);
  localparam int HW    = (CW > 4) ? CW : 4;
  localparam int FW    = ((CGW > HW + 5) ? CGW : HW + 5) + 1;
  localparam int NW    = 4 + CGW + SW;
  localparam int EW0   = $clog2(GRID_DIM + 1);
  localparam int EW    = ((EW0 > 5) ? EW0 : 5) + 1;
  localparam int XW    = (CW > 4) ? CW : 4;
  localparam int PW    = ((IW > 9) ? IW : 9) + 1;
  localparam int LXW   = ((LW > 9) ? LW : 9) + 1;

  typedef enum logic [3:0] {
    S_OCLR, S_IDLE, S_RD, S_SCLR, S_SINIT, S_SCAN, S_NB, S_NBW,
    S_CLOSE, S_T1R, S_T1W, S_T2R, S_T2W, S_DONE
  } state_t;

  state_t         state_r, state_nxt;
  in_t            item_r, item_nxt;
  logic [4:0]     rows_r, rows_nxt, cols_r, cols_nxt;
  logic [IW:0]    cnt_r, cnt_nxt;
  logic           chk_v_r, chk_v_nxt, have_r, have_nxt;
  logic [IW-1:0]  chk_a_r, chk_a_nxt, best_a_r, best_a_nxt;
  logic [FW-1:0]  best_f_r, best_f_nxt;
  logic [SW-1:0]  best_s_r, best_s_nxt, stamp_r, stamp_nxt;
  logic [CGW-1:0] best_c_r, best_c_nxt;
  logic [1:0]     best_p_r, best_p_nxt, dir_r, dir_nxt;
  logic [IW-1:0]  ni_r, ni_nxt, start_a_r, start_a_nxt, goal_a_r, goal_a_nxt;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  open_r, open_nxt, len_r, len_nxt, k_r, k_nxt;
  logic [LW-1:0]  stored_r, stored_nxt;
  logic           goal_ok_r, goal_ok_nxt, goal_open_r, goal_open_nxt;
  logic           found_r, found_nxt, bad_r, bad_nxt, out_valid_r, out_valid_nxt;
  logic [3:0]     srow_r, srow_nxt, scol_r, scol_nxt;
  out_t           out_r, out_nxt;

  // memory ports
  logic           obs_we, obs_wd, obs_rd;
  logic [IW-1:0]  obs_wa, obs_ra;
  logic           node_we;
  logic [IW-1:0]  node_wa, node_ra;
  logic [NW-1:0]  node_wd, node_rd;
  logic           pm_we;
  logic [IW-1:0]  pm_wa, pm_ra;
  logic [IW-1:0]  pm_wd, pm_rd;

  // node fields
  logic [1:0]     nd_st, nd_par;
  logic [CGW-1:0] nd_cost, g_new;
  logic [SW-1:0]  nd_stamp;

  // score unit
  logic [FW-1:0]  sc_f;
  logic           sc_better;

  // misc combinational
  logic [EW-1:0]  rows_eff, cols_eff;
  logic [CW-1:0]  br, bc;
  logic           nb_ok;
  logic [IW-1:0]  nb_a;
  logic [PW-1:0]  pidx_m1;
  logic [LXW-1:0] plen_x;
  logic [XW-1:0]  rd_r_x, rd_c_x;
  logic [LW-1:0]  open_dec;

  function automatic logic [IW-1:0] mk_addr(input logic [3:0] r, input logic [3:0] c);
    logic [XW-1:0] rx, cx;
    rx = XW'(r);
    cx = XW'(c);
    return {rx[CW-1:0], cx[CW-1:0]};
  endfunction

  function automatic logic [IW-1:0] mv(input logic [IW-1:0] a, input logic [1:0] d);
    logic [CW-1:0] r, c;
    r = a[IW-1:CW];
    c = a[CW-1:0];
    case (d)
      2'd0:    r = r - 1'b1;
      2'd1:    c = c + 1'b1;
      2'd2:    r = r + 1'b1;
      default: c = c - 1'b1;
    endcase
    return {r, c};
  endfunction

  function automatic logic [EW-1:0] eff_dim(input logic [4:0] v);
    logic [EW-1:0] vx;
    vx = EW'(v);
    if (v == 5'd0) begin
      return EW'(1);
    end else if (vx > EW'(GRID_DIM)) begin
      return EW'(GRID_DIM);
    end
    return vx;
  endfunction

  gaps_ram #(.AW(IW), .DW(1)) u_obs (
    .clk(clk), .we(obs_we), .waddr(obs_wa), .wdata(obs_wd),
    .raddr(obs_ra), .rdata(obs_rd)
  );

  gaps_ram #(.AW(IW), .DW(NW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_rd)
  );

  gaps_ram #(.AW(IW), .DW(IW)) u_path (
    .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd),
    .raddr(pm_ra), .rdata(pm_rd)
  );

  gaps_fscore #(.CW(CW), .CGW(CGW), .SW(SW), .FW(FW)) u_fscore (
    .cost(nd_cost), .row(chk_a_r[IW-1:CW]), .col(chk_a_r[CW-1:0]),
    .goal_row(item_r.goal_row), .goal_col(item_r.goal_col),
    .stamp(nd_stamp), .have(have_r), .best_f(best_f_r), .best_s(best_s_r),
    .f(sc_f), .better(sc_better)
  );

  // unpack node word and neighbour geometry
  always_comb begin
    {nd_st, nd_cost, nd_par, nd_stamp} = node_rd;
    rows_eff = eff_dim(rows_r);
    cols_eff = eff_dim(cols_r);
    br       = best_a_r[IW-1:CW];
    bc       = best_a_r[CW-1:0];
    g_new    = best_c_r + CGW'(STEP_COST);
    nb_a     = mv(best_a_r, dir_r);
    case (dir_r)
      2'd0:    nb_ok = (br != '0);
      2'd1:    nb_ok = (EW'(bc) + EW'(1)) < cols_eff;
      2'd2:    nb_ok = (EW'(br) + EW'(1)) < rows_eff;
      default: nb_ok = (bc != '0);
    endcase
    pidx_m1  = PW'(in_data.path_index) - PW'(1);
    plen_x   = LXW'(stored_r);
    rd_r_x   = XW'(pm_rd[IW-1:CW]);
    rd_c_x   = XW'(pm_rd[CW-1:0]);
    open_dec = open_r - LW'(1);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    cnt_nxt       = cnt_r;
    chk_v_nxt     = 1'b0;
    chk_a_nxt     = chk_a_r;
    have_nxt      = have_r;
    best_a_nxt    = best_a_r;
    best_f_nxt    = best_f_r;
    best_s_nxt    = best_s_r;
    best_c_nxt    = best_c_r;
    best_p_nxt    = best_p_r;
    dir_nxt       = dir_r;
    ni_nxt        = ni_r;
    start_a_nxt   = start_a_r;
    goal_a_nxt    = goal_a_r;
    cur_nxt       = cur_r;
    open_nxt      = open_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    stamp_nxt     = stamp_r;
    stored_nxt    = stored_r;
    goal_ok_nxt   = goal_ok_r;
    goal_open_nxt = goal_open_r;
    found_nxt     = found_r;
    bad_nxt       = bad_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    obs_we  = 1'b0;
    obs_wa  = mk_addr(item_r.row, item_r.col);
    obs_wd  = 1'b0;
    obs_ra  = nb_a;
    node_we = 1'b0;
    node_wa = nb_a;
    node_wd = '0;
    node_ra = cnt_r[IW-1:0];
    pm_we   = 1'b0;
    pm_wa   = IW'(k_r - LW'(1));
    pm_wd   = cur_r;
    pm_ra   = pidx_m1[IW-1:0];

    // configuration writes are taken in any state
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default:  rows_nxt = rows_r;
      endcase
    end

    unique case (state_r)
      // sweep the obstacle map free after reset
      S_OCLR: begin
        obs_we = 1'b1;
        obs_wa = cnt_r[IW-1:0];
        if (cnt_r == (IW+1)'(ND - 1)) begin
          state_nxt = S_IDLE;
        end
        cnt_nxt = cnt_r + 1'b1;
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          srow_nxt = '0;
          scol_nxt = '0;
          bad_nxt  = 1'b0;
          unique case (in_data.func)
            FN_FREE, FN_BLOCK: begin
              obs_wa = mk_addr(in_data.row, in_data.col);
              obs_wd = (in_data.func == FN_BLOCK);
              obs_we = (32'(in_data.row) < GRID_DIM) && (32'(in_data.col) < GRID_DIM);
              state_nxt = S_DONE;
            end
            FN_SEARCH: begin
              found_nxt  = 1'b0;
              stored_nxt = '0;
              cnt_nxt    = '0;
              state_nxt  = S_SCLR;
            end
            FN_READ: begin
              bad_nxt   = (in_data.path_index == 9'd0) ||
                          (LXW'(in_data.path_index) > plen_x);
              state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // path entry is on the read port now
      S_RD: begin
        if (!bad_r) begin
          srow_nxt = rd_r_x[3:0];
          scol_nxt = rd_c_x[3:0];
        end
        state_nxt = S_DONE;
      end

      // mark every node unvisited
      S_SCLR: begin
        if (cnt_r != (IW+1)'(ND)) begin
          node_we = 1'b1;
          node_wa = cnt_r[IW-1:0];
          node_wd = {ST_FREE, {(NW-2){1'b0}}};
          cnt_nxt = cnt_r + 1'b1;
        end else if ((EW'(item_r.row) < rows_eff) && (EW'(item_r.col) < cols_eff)) begin
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // open the start cell
      S_SINIT: begin
        start_a_nxt   = mk_addr(item_r.row, item_r.col);
        goal_ok_nxt   = (EW'(item_r.goal_row) < rows_eff) &&
                        (EW'(item_r.goal_col) < cols_eff);
        goal_a_nxt    = mk_addr(item_r.goal_row, item_r.goal_col);
        goal_open_nxt = goal_ok_nxt && (goal_a_nxt == start_a_nxt);
        node_we       = 1'b1;
        node_wa       = start_a_nxt;
        node_wd       = {ST_OPEN, {(NW-2){1'b0}}};
        open_nxt      = LW'(1);
        stamp_nxt     = SW'(1);
        if (goal_open_nxt) begin
          len_nxt   = LW'(1);
          cur_nxt   = goal_a_nxt;
          state_nxt = S_T1R;
        end else begin
          cnt_nxt   = '0;
          have_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      // walk all nodes, keep the best open one
      S_SCAN: begin
        if (chk_v_r && (nd_st == ST_OPEN) && sc_better) begin
          have_nxt   = 1'b1;
          best_a_nxt = chk_a_r;
          best_f_nxt = sc_f;
          best_s_nxt = nd_stamp;
          best_c_nxt = nd_cost;
          best_p_nxt = nd_par;
        end
        if (cnt_r != (IW+1)'(ND)) begin
          node_ra   = cnt_r[IW-1:0];
          chk_v_nxt = 1'b1;
          chk_a_nxt = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          dir_nxt   = 2'd0;
          state_nxt = S_NB;
        end
      end

      // issue reads for the next neighbour in bounds
      S_NB: begin
        obs_ra  = nb_a;
        node_ra = nb_a;
        ni_nxt  = nb_a;
        if (nb_ok) begin
          state_nxt = S_NBW;
        end else if (dir_r == 2'd3) begin
          state_nxt = S_CLOSE;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end

      // relax or open the neighbour
      S_NBW: begin
        node_wa = ni_r;
        if (!obs_rd) begin
          if (nd_st == ST_OPEN) begin
            if (nd_cost > g_new) begin
              node_we = 1'b1;
              node_wd = {ST_OPEN, g_new, dir_r + 2'd2, nd_stamp};
            end
          end else if (nd_st == ST_FREE) begin
            node_we   = 1'b1;
            node_wd   = {ST_OPEN, g_new, dir_r + 2'd2, stamp_r};
            stamp_nxt = stamp_r + 1'b1;
            open_nxt  = open_r + 1'b1;
            if (goal_ok_r && (ni_r == goal_a_r)) begin
              goal_open_nxt = 1'b1;
            end
          end
        end
        if (dir_r == 2'd3) begin
          state_nxt = S_CLOSE;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NB;
        end
      end

      // close the expanded cell and decide how to go on
      S_CLOSE: begin
        node_we  = 1'b1;
        node_wa  = best_a_r;
        node_wd  = {ST_CLOSED, best_c_r, best_p_r, best_s_r};
        open_nxt = open_dec;
        if (open_dec == '0) begin
          state_nxt = S_DONE;
        end else if (goal_open_r) begin
          len_nxt   = LW'(1);
          cur_nxt   = goal_a_r;
          state_nxt = S_T1R;
        end else begin
          cnt_nxt   = '0;
          have_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      // first pass: count path cells back from the goal
      S_T1R: begin
        node_ra = cur_r;
        if ((cur_r == start_a_r) || (len_r >= LW'(CELLS))) begin
          k_nxt     = len_r;
          cur_nxt   = goal_a_r;
          state_nxt = S_T2R;
        end else begin
          state_nxt = S_T1W;
        end
      end

      S_T1W: begin
        cur_nxt   = mv(cur_r, nd_par);
        len_nxt   = len_r + 1'b1;
        state_nxt = S_T1R;
      end

      // second pass: store cells from the goal end down
      S_T2R: begin
        pm_we     = 1'b1;
        node_ra   = cur_r;
        state_nxt = S_T2W;
      end

      S_T2W: begin
        cur_nxt = mv(cur_r, nd_par);
        k_nxt   = k_r - 1'b1;
        if (k_r == LW'(1)) begin
          found_nxt  = 1'b1;
          stored_nxt = len_r;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_T2R;
        end
      end

      // load the result once the output slot is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.found       = found_r;
          out_nxt.path_length = (plen_x > LXW'(511)) ? 9'd511 : plen_x[8:0];
          out_nxt.step_row    = srow_r;
          out_nxt.step_col    = scol_r;
          out_nxt.index_bad   = bad_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_OCLR;
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      stored_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      stored_r    <= stored_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    chk_a_r     <= chk_a_nxt;
    have_r      <= have_nxt;
    best_a_r    <= best_a_nxt;
    best_f_r    <= best_f_nxt;
    best_s_r    <= best_s_nxt;
    best_c_r    <= best_c_nxt;
    best_p_r    <= best_p_nxt;
    dir_r       <= dir_nxt;
    ni_r        <= ni_nxt;
    start_a_r   <= start_a_nxt;
    goal_a_r    <= goal_a_nxt;
    cur_r       <= cur_nxt;
    open_r      <= open_nxt;
    len_r       <= len_nxt;
    k_r         <= k_nxt;
    stamp_r     <= stamp_nxt;
    goal_ok_r   <= goal_ok_nxt;
    goal_open_r <= goal_open_nxt;
    bad_r       <= bad_nxt;
    srow_r      <= srow_nxt;
    scol_r      <= scol_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/gaps_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaps_chk
// Port-level checks of the grid path search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_unit_defines.svh"

module gaps_chk
  import gaps_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // one item at a time: a transfer in drops ready
  `GAPS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // a stalled result stays and holds
  `GAPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `GAPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  // a bad read returns no cell
  `GAPS_ASSERT_NOW(a_bad_zero, out_valid && out_data.index_bad,
                   out_data.step_row == 4'd0 && out_data.step_col == 4'd0)
  // no stored path without a found search
  `GAPS_ASSERT_NOW(a_len_found, out_valid && !out_data.found,
                   out_data.path_length == 9'd0)

endmodule

bind grid_astar_path_search_unit gaps_chk u_gaps_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid path search unit. Drives cell updates,
// searches and path reads through the valid/ready input channel, predicts
// each result with an in-bench A* model that tracks the obstacle grid, the
// stored path and the area registers, and compares every result transfer
// field by field. Input gaps and output stalls are random, with bursts of
// back-to-back traffic; the area registers are swept between phases.
// ----------------------------------------------------------------------------
module tb;
  import gaps_pkg::*;

  localparam int DIM        = GRID_DIM_DEF;
  localparam int CELL_COUNT = DIM * DIM;
  localparam int IDLE_LIMIT = 250000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_ROWS;
  logic [4:0] cfg_wdata = '0;

  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int idle_cycles = 0;

  grid_astar_path_search_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Grid model: obstacle map, search state, stored path and expected results
  class path_scoreboard;
    bit          blocked[CELL_COUNT];
    logic [1:0]  status[CELL_COUNT];
    int          g_cost[CELL_COUNT];
    int          stamp[CELL_COUNT];
    logic [1:0]  back_dir[CELL_COUNT];
    logic [3:0]  path_r[CELL_COUNT];
    logic [3:0]  path_c[CELL_COUNT];
    int          path_len;
    bit          path_found;
    logic [4:0]  rows_reg;
    logic [4:0]  cols_reg;
    out_t        result_q[$];
    int          errors;

    function new();
      foreach (blocked[i]) blocked[i] = 1'b0;
      path_len = 0;
      path_found = 1'b0;
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      errors = 0;
    endfunction

    function int area(logic [4:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
    endfunction

    function int step_to(int cur, logic [1:0] d);
      case (d)
        2'd0: return (cur + CELL_COUNT - DIM) % CELL_COUNT;
        2'd1: return (cur + 1) % CELL_COUNT;
        2'd2: return (cur + DIM) % CELL_COUNT;
        default: return (cur + CELL_COUNT - 1) % CELL_COUNT;
      endcase
    endfunction

    function void run_search(int sr, int sc, int gr, int gc);
      int rows, cols, start, goal, open_n, next_stamp, best, bf, bs, f;
      int br, bc, g, ni, cur, dr, dc;
      bit goal_ok, have, ok;
      rows = area(rows_reg);
      cols = area(cols_reg);
      path_len = 0;
      path_found = 1'b0;
      foreach (status[i]) status[i] = ST_FREE;
      if (sr >= rows || sc >= cols) return;
      goal_ok = (gr < rows && gc < cols);
      goal = goal_ok ? gr * DIM + gc : 0;
      start = sr * DIM + sc;
      status[start] = ST_OPEN;
      g_cost[start] = 0;
      stamp[start] = 0;
      next_stamp = 1;
      open_n = 1;
      while (open_n > 0 && !(goal_ok && status[goal] == ST_OPEN)) begin
        have = 1'b0;
        best = 0;
        bf = 0;
        bs = 0;
        // pick lowest F, latest opened on a tie
        for (int i = 0; i < CELL_COUNT; i++) begin
          if (status[i] == ST_OPEN) begin
            dr = gr - i / DIM;
            dc = gc - i % DIM;
            if (dr < 0) dr = -dr;
            if (dc < 0) dc = -dc;
            f = g_cost[i] + STEP_COST * (dr + dc);
            if (!have || f < bf || (f == bf && stamp[i] > bs)) begin
              have = 1'b1;
              best = i;
              bf = f;
              bs = stamp[i];
            end
          end
        end
        br = best / DIM;
        bc = best % DIM;
        g = g_cost[best] + STEP_COST;
        for (int d = 0; d < 4; d++) begin
          case (d)
            0: ok = br > 0;
            1: ok = bc + 1 < cols;
            2: ok = br + 1 < rows;
            default: ok = bc > 0;
          endcase
          if (!ok) continue;
          ni = step_to(best, d[1:0]);
          if (blocked[ni]) continue;
          if (status[ni] == ST_OPEN) begin
            if (g_cost[ni] > g) begin
              g_cost[ni] = g;
              back_dir[ni] = d[1:0] + 2'd2;
            end
          end else if (status[ni] == ST_FREE) begin
            status[ni] = ST_OPEN;
            g_cost[ni] = g;
            back_dir[ni] = d[1:0] + 2'd2;
            stamp[ni] = next_stamp;
            next_stamp++;
            open_n++;
          end
        end
        status[best] = ST_CLOSED;
        open_n--;
      end
      if (open_n == 0) return;
      // walk the parent chain back from the goal
      path_len = 1;
      cur = goal;
      while (cur != start && path_len < CELL_COUNT) begin
        cur = step_to(cur, back_dir[cur]);
        path_len++;
      end
      cur = goal;
      for (int k = path_len; k > 0; k--) begin
        path_r[k - 1] = 4'(cur / DIM);
        path_c[k - 1] = 4'(cur % DIM);
        cur = step_to(cur, back_dir[cur]);
      end
      path_found = 1'b1;
    endfunction

    function void note_transfer(in_t x);
      out_t res;
      res = '0;
      case (x.func)
        FN_FREE, FN_BLOCK: blocked[x.row * DIM + x.col] = (x.func == FN_BLOCK);
        FN_SEARCH: run_search(x.row, x.col, x.goal_row, x.goal_col);
        default: begin
          if (x.path_index == 0 || x.path_index > path_len) begin
            res.index_bad = 1'b1;
          end else begin
            res.step_row = path_r[x.path_index - 1];
            res.step_col = path_c[x.path_index - 1];
          end
        end
      endcase
      res.found = path_found;
      res.path_length = (path_len > 511) ? 9'd511 : path_len[8:0];
      result_q = {result_q, res};
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (result_q.size() == 0) begin
        report("unexpected result", int'(got), 0);
        return;
      end
      want = result_q.pop_front();
      if (got.found !== want.found) report("found", int'(got.found), int'(want.found));
      if (got.path_length !== want.path_length)
        report("path_length", int'(got.path_length), int'(want.path_length));
      if (got.step_row !== want.step_row)
        report("step_row", int'(got.step_row), int'(want.step_row));
      if (got.step_col !== want.step_col)
        report("step_col", int'(got.step_col), int'(want.step_col));
      if (got.index_bad !== want.index_bad)
        report("index_bad", int'(got.index_bad), int'(want.index_bad));
    endtask
  endclass

  path_scoreboard grid_sb = new();

  always #4 clk = ~clk;

  // Hang detection: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, check each transfer
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : int'($urandom_range(0, 12));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      grid_sb.check_result(out_data);
    end
  end

  task send_item(in_t x);
    int gap;
    gap = in_burst ? 0 : int'($urandom_range(0, 12));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    grid_sb.note_transfer(x);
  endtask

  task set_cell(func_t f, int r, int c);
    in_t x;
    x = '0;
    x.func = f;
    x.row = 4'(r);
    x.col = 4'(c);
    send_item(x);
  endtask

  task search(int r, int c, int gr, int gc);
    in_t x;
    x = '0;
    x.func = FN_SEARCH;
    x.row = 4'(r);
    x.col = 4'(c);
    x.goal_row = 4'(gr);
    x.goal_col = 4'(gc);
    send_item(x);
  endtask

  task read_entry(int idx);
    in_t x;
    x = '0;
    x.func = FN_READ;
    x.path_index = 9'(idx);
    send_item(x);
  endtask

  // Drain: hold input off until every expected result has arrived
  task drain();
    in_valid <= 1'b0;
    while (grid_sb.result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_area(logic [4:0] rows, logic [4:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    grid_sb.rows_reg = rows;
    cfg_index <= REG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    grid_sb.cols_reg = cols;
    cfg_we <= 1'b0;
  endtask

  // Random item: cell edits, searches and path reads, mostly inside the area
  task random_item();
    in_t x;
    int rows, cols, pick;
    rows = grid_sb.area(grid_sb.rows_reg);
    cols = grid_sb.area(grid_sb.cols_reg);
    x = '0;
    x.goal_row = 4'($urandom_range(0, 15));
    x.goal_col = 4'($urandom_range(0, 15));
    x.path_index = 9'($urandom_range(0, 511));
    x.row = 4'($urandom_range(0, 15));
    x.col = 4'($urandom_range(0, 15));
    pick = int'($urandom_range(0, 9));
    if (pick < 4) begin
      x.func = ($urandom_range(0, 2) == 0) ? FN_BLOCK : FN_FREE;
      if ($urandom_range(0, 4) != 0) begin
        x.row = 4'($urandom_range(0, rows - 1));
        x.col = 4'($urandom_range(0, cols - 1));
      end
    end else if (pick < 7) begin
      x.func = FN_SEARCH;
      if ($urandom_range(0, 9) != 0) begin
        x.row = 4'($urandom_range(0, rows - 1));
        x.col = 4'($urandom_range(0, cols - 1));
        x.goal_row = 4'($urandom_range(0, rows - 1));
        x.goal_col = 4'($urandom_range(0, cols - 1));
      end
    end else begin
      x.func = FN_READ;
      if (grid_sb.path_len > 0 && $urandom_range(0, 4) != 0)
        x.path_index = 9'($urandom_range(1, grid_sb.path_len + 1));
    end
    send_item(x);
  endtask

  initial begin
    logic [4:0] area_set[5][2];
    area_set = '{'{5'd0, 5'd31}, '{5'd16, 5'd16}, '{5'd1, 5'd16},
                 '{5'd16, 5'd1}, '{5'd7, 5'd11}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty path reads, corner cases of search at reset area
    read_entry(0);
    read_entry(1);
    read_entry(256);
    read_entry(511);
    set_cell(FN_BLOCK, 5, 5);
    search(5, 5, 5, 5);
    read_entry(1);
    search(0, 0, 12, 12);
    read_entry(1);
    read_entry(grid_sb.path_len);
    read_entry(grid_sb.path_len + 1);
    search(13, 0, 2, 2);
    search(0, 0, 15, 15);
    set_cell(FN_BLOCK, 15, 15);
    set_cell(FN_FREE, 15, 15);
    set_cell(FN_BLOCK, 0, 0);
    search(0, 0, 3, 2);
    set_cell(FN_FREE, 0, 0);
    set_cell(FN_BLOCK, 11, 12);
    set_cell(FN_BLOCK, 12, 11);
    search(6, 6, 12, 12);
    set_cell(FN_FREE, 11, 12);
    search(12, 12, 6, 6);
    read_entry(3);

    // Random phases across area settings, including the extremes
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph > 0) write_area(area_set[ph - 1][0], area_set[ph - 1][1]);
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (grid_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/gaps_pkg.sv
rtl/core/gaps_ram.sv
rtl/core/gaps_fscore.sv
rtl/core/grid_astar_path_search_unit.sv
rtl/core/gaps_chk.sv
test/tb.sv
